[hdl/hsl_pkg.sv]
// shared types, constants and lane codes for the rgb to hsl converter
package hsl_pkg;

  // default number of fraction bits in hue, saturation and lightness
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // port field widths
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned OUT_FRAC_W = 16;

  // divider lanes, one per computed fraction
  localparam int unsigned LANES      = 3;
  localparam int unsigned LANE_HUE   = 0;
  localparam int unsigned LANE_SAT   = 1;
  localparam int unsigned LANE_LIGHT = 2;

  // divisor and partial remainder width (largest divisor is 12 * 255)
  localparam int unsigned DIV_W  = 12;
  // numerator bits above the quotient bits (largest head is 6 * 255)
  localparam int unsigned HEAD_W = 11;

  // lightness rounds (max + min) * one / 510: divisor 2 * 510, bias 510
  localparam int unsigned LIGHT_DEN  = 1020;
  localparam int unsigned LIGHT_HALF = 510;

  // input beat
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha_in;
  } hsl_pixel_t;

  // output beat
  typedef struct packed {
    logic [OUT_FRAC_W-1:0] hue;
    logic [OUT_FRAC_W-1:0] saturation;
    logic [OUT_FRAC_W-1:0] lightness;
    logic [CHAN_W-1:0]     alpha_out;
  } hsl_result_t;

  // side information that rides along the divider row
  typedef struct packed {
    logic              grey;
    logic [CHAN_W-1:0] alpha;
  } hsl_ctrl_t;

endpackage

[hdl/hsl_prep.sv]
// front end: max/min, sector, delta and the numerators and divisors of the three divisions
module hsl_prep #(
  parameter int unsigned QUO_W = 17
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             valid_i,
  input  hsl_pkg::hsl_pixel_t                              pixel_i,
  output logic                                             valid_o,
  output hsl_pkg::hsl_ctrl_t                               ctrl_o,
  output logic [hsl_pkg::LANES-1:0][hsl_pkg::DIV_W-1:0]    rem_o,
  output logic [hsl_pkg::LANES-1:0][QUO_W-1:0]             low_o,
  output logic [hsl_pkg::LANES-1:0][hsl_pkg::DIV_W-1:0]    den_o
);
  import hsl_pkg::*;

  localparam int unsigned NUM_W = HEAD_W + QUO_W;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } hsl_sector_e;

  // stage a registers
  logic              a_valid_q;
  logic [CHAN_W-1:0] a_r_q, a_g_q, a_b_q, a_mx_q, a_mn_q, a_alpha_q;
  hsl_sector_e       a_sec_q;

  // stage b registers
  logic              b_valid_q;
  logic [CHAN_W-1:0] b_d_q, b_den_q, b_alpha_q;
  logic [CHAN_W:0]   b_sum_q;
  logic [10:0]       b_d6_q, b_n_q;
  logic              b_grey_q;

  // stage c registers (head of the divider row)
  logic                              c_valid_q;
  hsl_ctrl_t                         c_ctrl_q;
  logic [LANES-1:0][DIV_W-1:0]       c_rem_q, c_den_q;
  logic [LANES-1:0][QUO_W-1:0]       c_low_q;

  // stage a: largest and smallest channel, red winning ties for the largest, then green
  hsl_sector_e       a_sec_d;
  logic [CHAN_W-1:0] a_mx_d, a_mn_d, mn_rg;

  always_comb begin
    if (pixel_i.red >= pixel_i.green && pixel_i.red >= pixel_i.blue) begin
      a_sec_d = SEC_RED;
      a_mx_d  = pixel_i.red;
    end else if (pixel_i.green >= pixel_i.blue) begin
      a_sec_d = SEC_GREEN;
      a_mx_d  = pixel_i.green;
    end else begin
      a_sec_d = SEC_BLUE;
      a_mx_d  = pixel_i.blue;
    end
    mn_rg  = (pixel_i.red < pixel_i.green) ? pixel_i.red : pixel_i.green;
    a_mn_d = (pixel_i.blue < mn_rg) ? pixel_i.blue : mn_rg;
  end

  // stage b: delta, sum, saturation divisor and sector numerator
  logic [CHAN_W-1:0] b_d_d, b_den_d;
  logic [CHAN_W:0]   b_sum_d;
  logic [10:0]       b_d6_d, b_n_d;

  always_comb begin
    b_d_d   = a_mx_q - a_mn_q;
    b_sum_d = {1'b0, a_mx_q} + {1'b0, a_mn_q};
    b_den_d = (b_sum_d > 9'd255) ? CHAN_W'(9'd510 - b_sum_d) : CHAN_W'(b_sum_d);
    b_d6_d  = (11'(b_d_d) << 2) + (11'(b_d_d) << 1);
    case (a_sec_q)
      SEC_RED: begin
        if (a_g_q < a_b_q) begin
          b_n_d = b_d6_d + 11'(a_g_q) - 11'(a_b_q);
        end else begin
          b_n_d = 11'(a_g_q) - 11'(a_b_q);
        end
      end
      SEC_GREEN: b_n_d = (11'(b_d_d) << 1) + 11'(a_b_q) - 11'(a_r_q);
      default:   b_n_d = (11'(b_d_d) << 2) + 11'(a_r_q) - 11'(a_g_q);
    endcase
  end

  // stage c: rounded-division numerators, split into head and low bits
  logic [NUM_W-1:0]              hue_num, sat_num, light_num;
  logic [LANES-1:0][DIV_W-1:0]   c_rem_d, c_den_d;
  logic [LANES-1:0][QUO_W-1:0]   c_low_d;

  always_comb begin
    hue_num   = (NUM_W'(b_n_q) << QUO_W) + NUM_W'(b_d6_q);
    sat_num   = (NUM_W'(b_d_q) << QUO_W) - (NUM_W'(b_d_q) << 1) + NUM_W'(b_den_q);
    light_num = (NUM_W'(b_sum_q) << QUO_W) - (NUM_W'(b_sum_q) << 1)
              + NUM_W'(LIGHT_HALF);

    c_rem_d[LANE_HUE]   = DIV_W'(hue_num[NUM_W-1:QUO_W]);
    c_rem_d[LANE_SAT]   = DIV_W'(sat_num[NUM_W-1:QUO_W]);
    c_rem_d[LANE_LIGHT] = DIV_W'(light_num[NUM_W-1:QUO_W]);

    c_low_d[LANE_HUE]   = hue_num[QUO_W-1:0];
    c_low_d[LANE_SAT]   = sat_num[QUO_W-1:0];
    c_low_d[LANE_LIGHT] = light_num[QUO_W-1:0];

    c_den_d[LANE_HUE]   = DIV_W'({b_d6_q, 1'b0});
    c_den_d[LANE_SAT]   = DIV_W'({b_den_q, 1'b0});
    c_den_d[LANE_LIGHT] = DIV_W'(LIGHT_DEN);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_r_q     <= pixel_i.red;
      a_g_q     <= pixel_i.green;
      a_b_q     <= pixel_i.blue;
      a_mx_q    <= a_mx_d;
      a_mn_q    <= a_mn_d;
      a_sec_q   <= a_sec_d;
      a_alpha_q <= pixel_i.alpha_in;

      b_d_q     <= b_d_d;
      b_sum_q   <= b_sum_d;
      b_den_q   <= b_den_d;
      b_d6_q    <= b_d6_d;
      b_n_q     <= b_n_d;
      b_grey_q  <= (b_d_d == '0);
      b_alpha_q <= a_alpha_q;

      c_rem_q        <= c_rem_d;
      c_low_q        <= c_low_d;
      c_den_q        <= c_den_d;
      c_ctrl_q.grey  <= b_grey_q;
      c_ctrl_q.alpha <= b_alpha_q;
    end
  end

  assign valid_o = c_valid_q;
  assign ctrl_o  = c_ctrl_q;
  assign rem_o   = c_rem_q;
  assign low_o   = c_low_q;
  assign den_o   = c_den_q;

endmodule

[hdl/hsl_div_cell.sv]
// one cell of the divider row: one restoring quotient bit for each of the three lanes
module hsl_div_cell #(
  parameter int unsigned QUO_W = 17
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  hsl_pkg::hsl_ctrl_t                            ctrl_i,
  input  logic [hsl_pkg::LANES-1:0][hsl_pkg::DIV_W-1:0] rem_i,
  input  logic [hsl_pkg::LANES-1:0][QUO_W-1:0]          low_i,
  input  logic [hsl_pkg::LANES-1:0][hsl_pkg::DIV_W-1:0] den_i,
  input  logic [hsl_pkg::LANES-1:0][QUO_W-1:0]          quo_i,
  output logic                                          valid_o,
  output hsl_pkg::hsl_ctrl_t                            ctrl_o,
  output logic [hsl_pkg::LANES-1:0][hsl_pkg::DIV_W-1:0] rem_o,
  output logic [hsl_pkg::LANES-1:0][QUO_W-1:0]          low_o,
  output logic [hsl_pkg::LANES-1:0][hsl_pkg::DIV_W-1:0] den_o,
  output logic [hsl_pkg::LANES-1:0][QUO_W-1:0]          quo_o
);
  import hsl_pkg::*;

  logic                          valid_q;
  hsl_ctrl_t                     ctrl_q;
  logic [LANES-1:0][DIV_W-1:0]   rem_q, den_q, rem_d;
  logic [LANES-1:0][QUO_W-1:0]   low_q, quo_q, low_d, quo_d;

  // shift in the next numerator bit, subtract the divisor when it fits
  always_comb begin
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           fits;
    for (int k = 0; k < LANES; k++) begin
      trial    = {rem_i[k], low_i[k][QUO_W-1]};
      diff     = trial - {1'b0, den_i[k]};
      fits     = (trial >= {1'b0, den_i[k]});
      rem_d[k] = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      low_d[k] = {low_i[k][QUO_W-2:0], 1'b0};
      quo_d[k] = {quo_i[k][QUO_W-2:0], fits};
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q <= ctrl_i;
      rem_q  <= rem_d;
      low_q  <= low_d;
      den_q  <= den_i;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign rem_o   = rem_q;
  assign low_o   = low_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;

endmodule

[hdl/hsl_out_buf.sv]
// output register with a skid stage, holds the pipeline only when both are full
module hsl_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tail_valid_i,
  input  hsl_pkg::hsl_result_t tail_data_i,
  output logic                 en_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hsl_pkg::hsl_result_t out_data_o
);
  import hsl_pkg::*;

  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  hsl_result_t out_data_q, out_data_d, skid_data_q, skid_data_d;

  // beat routing between pipeline tail, skid and output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (tail_valid_i) begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_d = 1'b1;
        out_data_d  = tail_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = tail_data_i;
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign en_o        = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hdl/rgb_to_hsl_converter.sv]
// top level of the rgb to hsl converter
//
// Input channel: one RGBA pixel per beat (in_valid_i, in_stall_o, in_data_i).
// Output channel: hue, saturation, lightness and alpha per beat
// (out_valid_o, out_stall_i, out_data_o). Every pixel gives exactly one result,
// in order. Hue counts 2^FRACTION_BITS per turn; saturation and lightness use
// 2^FRACTION_BITS - 1 for 1.0; the 16-bit fields keep the low bits.
// Throughput: one pixel per clock while no stall holds the row. The accepting
// edge loads the first of three front-end stages; a row of FRACTION_BITS + 1
// divider cells (one quotient bit per cell for all three divisions) and the
// output register follow.
// When the receiver stalls, the output register holds its beat and one more
// result drops into a skid stage; only then does in_stall_o rise and the whole
// row hold. in_stall_o is registered and falls in the cycle after the output
// beat is taken.
// Reset clears all valid bits; nothing in flight survives it.
module rgb_to_hsl_converter #(
  parameter int unsigned FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hsl_pkg::hsl_pixel_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hsl_pkg::hsl_result_t out_data_o
);
  import hsl_pkg::*;

  localparam int unsigned QUO_W     = FRACTION_BITS + 1;
  localparam int unsigned NUM_CELLS = QUO_W;

  logic                                        en;
  logic [NUM_CELLS:0]                          valid_c;
  hsl_ctrl_t                                   ctrl_c [NUM_CELLS:0];
  logic [NUM_CELLS:0][LANES-1:0][DIV_W-1:0]    rem_c, den_c;
  logic [NUM_CELLS:0][LANES-1:0][QUO_W-1:0]    low_c, quo_c;
  hsl_result_t                                 tail_data;

  // front end
  hsl_prep #(
    .QUO_W (QUO_W)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i && !in_stall_o),
    .pixel_i (in_data_i),
    .valid_o (valid_c[0]),
    .ctrl_o  (ctrl_c[0]),
    .rem_o   (rem_c[0]),
    .low_o   (low_c[0]),
    .den_o   (den_c[0])
  );

  assign quo_c[0] = '0;

  // divider row
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    hsl_div_cell #(
      .QUO_W (QUO_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[i]),
      .ctrl_i  (ctrl_c[i]),
      .rem_i   (rem_c[i]),
      .low_i   (low_c[i]),
      .den_i   (den_c[i]),
      .quo_i   (quo_c[i]),
      .valid_o (valid_c[i+1]),
      .ctrl_o  (ctrl_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .low_o   (low_c[i+1]),
      .den_o   (den_c[i+1]),
      .quo_o   (quo_c[i+1])
    );
  end

  // result formatting: hue wraps a full turn, grey pixels give zero hue and saturation
  always_comb begin
    tail_data.hue        = ctrl_c[NUM_CELLS].grey ? '0 :
                           OUT_FRAC_W'(quo_c[NUM_CELLS][LANE_HUE][QUO_W-2:0]);
    tail_data.saturation = ctrl_c[NUM_CELLS].grey ? '0 :
                           OUT_FRAC_W'(quo_c[NUM_CELLS][LANE_SAT][QUO_W-2:0]);
    tail_data.lightness  = OUT_FRAC_W'(quo_c[NUM_CELLS][LANE_LIGHT][QUO_W-2:0]);
    tail_data.alpha_out  = ctrl_c[NUM_CELLS].alpha;
  end

  // output register and skid
  hsl_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tail_valid_i (valid_c[NUM_CELLS]),
    .tail_data_i  (tail_data),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  assign in_stall_o = !en;

endmodule

[hdl/hsl_chk.sv]
// port-level checks for the rgb to hsl converter, bound to the top level
module hsl_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input hsl_pkg::hsl_result_t out_data_o
);

  // a stalled output beat stays valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // input stall only follows a stalled output beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output beat");

  // the skid drains as soon as the output beat is taken
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after the output drained");

  // nothing comes out and the input is not stalled right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("output valid or input stalled right after reset");

endmodule

bind rgb_to_hsl_converter hsl_chk u_hsl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[test/hsl_checker.sv]
// beat monitor, hsl predictor and result checker for the rgb to hsl converter
module hsl_checker #(
  parameter int unsigned FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  hsl_pkg::hsl_pixel_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  hsl_pkg::hsl_result_t out_data_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import hsl_pkg::*;

  localparam longint unsigned TURN = 64'd1 << FRACTION_BITS;
  localparam longint unsigned UNIT = TURN - 1;

  hsl_result_t expected_results[$];

  // round to nearest, halves up
  function automatic longint unsigned rounded_quotient(longint unsigned num,
                                                       longint unsigned den);
    return (num * 2 + den) / (den * 2);
  endfunction

  // expected hue, saturation and lightness of one pixel
  function automatic hsl_result_t convert_pixel(hsl_pixel_t px);
    longint unsigned r, g, b, hi, lo, sum, delta, den, pos, hue, sat, light;
    hsl_result_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    sum = hi + lo;
    delta = hi - lo;
    light = rounded_quotient(sum * UNIT, 510);
    hue = 0;
    sat = 0;
    if (delta != 0) begin
      den = (sum > 255) ? (510 - sum) : sum;
      sat = rounded_quotient(delta * UNIT, den);
      // sector position in units of delta, red first, then green, then blue
      if (hi == r) begin
        if (g < b) pos = 6 * delta - (b - g);
        else pos = g - b;
      end else if (hi == g) begin
        pos = 2 * delta + b - r;
      end else begin
        pos = 4 * delta + r - g;
      end
      hue = rounded_quotient(pos * TURN, 6 * delta) & (TURN - 1);
    end
    res.hue        = hue[OUT_FRAC_W-1:0];
    res.saturation = sat[OUT_FRAC_W-1:0];
    res.lightness  = light[OUT_FRAC_W-1:0];
    res.alpha_out  = px.alpha_in;
    return res;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      if (errors_o < 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      end
      errors_o++;
    end
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
  end

  // compare each output beat, then queue the prediction for each input beat
  always @(posedge clk_i) begin
    hsl_result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (errors_o < 10) begin
            $display("%0t: result beat with nothing expected (hue %0d)",
                     $realtime, out_data_i.hue);
          end
          errors_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("hue", want.hue, out_data_i.hue);
          check_field("saturation", want.saturation, out_data_i.saturation);
          check_field("lightness", want.lightness, out_data_i.lightness);
          check_field("alpha", want.alpha_out, out_data_i.alpha_out);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(convert_pixel(in_data_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[test/testbench.sv]
// pixel stimulus and verdict for the rgb to hsl converter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsl_pkg::*;

  localparam int unsigned LATENCY     = FRACTION_BITS_DEF + 5;
  localparam int unsigned RANDOM_BEATS = 1030;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        pixel_valid;
  logic        pixel_stall;
  hsl_pixel_t  pixel_data;
  logic        result_valid;
  logic        result_stall;
  hsl_result_t result_data;
  int          errors;
  int          pending;
  int          cycles;
  bit          quiet;
  bit          hold_req;

  rgb_to_hsl_converter dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (pixel_valid),
    .in_stall_o (pixel_stall),
    .in_data_i  (pixel_data),
    .out_valid_o(result_valid),
    .out_stall_i(result_stall),
    .out_data_o (result_data)
  );

  hsl_checker result_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (pixel_valid),
    .in_stall_i (pixel_stall),
    .in_data_i  (pixel_data),
    .out_valid_i(result_valid),
    .out_stall_i(result_stall),
    .out_data_i (result_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // offer one pixel beat, with random idle cycles before it unless quiet
  task automatic send_pixel(input hsl_pixel_t px);
    while (!quiet && $urandom_range(99) < 20) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_data  <= px;
    do @(posedge clk); while (pixel_stall);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // greys, channel ties, extremes and plain random pixels
  function automatic hsl_pixel_t random_pixel();
    hsl_pixel_t px;
    int unsigned kind;
    kind = $urandom_range(99);
    px.red      = 8'($urandom_range(255));
    px.green    = 8'($urandom_range(255));
    px.blue     = 8'($urandom_range(255));
    px.alpha_in = 8'($urandom_range(255));
    if (kind < 10) begin
      px.green = px.red;
      px.blue  = px.red;
    end else if (kind < 22) begin
      case ($urandom_range(2))
        0:       px.green = px.red;
        1:       px.blue = px.green;
        default: px.blue = px.red;
      endcase
    end else if (kind < 32) begin
      px.red   = pick_channel();
      px.green = pick_channel();
      px.blue  = pick_channel();
    end
    return px;
  endfunction

  // receiver: random stalls, a long hold-off on request, none when quiet
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        result_stall <= !quiet && ($urandom_range(99) < 20);
      end
    end
  end

  // stimulus and verdict
  initial begin
    hsl_pixel_t directed[$];
    rst_n       = 1'b0;
    pixel_valid = 1'b0;
    pixel_data  = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // black, white, grey, primaries, ties, lightness boundaries, bit patterns
    directed = '{
      '{8'h00, 8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h80, 8'h80, 8'h80, 8'h5A}, '{8'hFF, 8'h00, 8'h00, 8'hA5},
      '{8'h00, 8'hFF, 8'h00, 8'h01}, '{8'h00, 8'h00, 8'hFF, 8'hFE},
      '{8'hFF, 8'hFF, 8'h00, 8'h55}, '{8'h00, 8'hFF, 8'hFF, 8'hAA},
      '{8'hFF, 8'h00, 8'hFF, 8'h33}, '{8'hFF, 8'h00, 8'h01, 8'hCC},
      '{8'hFF, 8'h01, 8'h00, 8'h0F}, '{8'h01, 8'h00, 8'hFF, 8'hF0},
      '{8'hC8, 8'h64, 8'h32, 8'h12}, '{8'h32, 8'hC8, 8'h64, 8'h34},
      '{8'h64, 8'h32, 8'hC8, 8'h56}, '{8'hFF, 8'hFE, 8'hFE, 8'h78},
      '{8'h01, 8'h00, 8'h00, 8'h9A}, '{8'h80, 8'h7F, 8'h7F, 8'hBC},
      '{8'h80, 8'h80, 8'h7F, 8'hDE}, '{8'h81, 8'h7F, 8'h7F, 8'h80},
      '{8'hAA, 8'h55, 8'h00, 8'h7F}, '{8'h55, 8'hAA, 8'hFF, 8'h00}
    };
    foreach (directed[i]) send_pixel(directed[i]);

    // sender pauses until everything has come back
    pixel_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 100) hold_req = 1'b1;
      quiet = (i >= 500 && i < 700);
      if (i == 800) begin
        pixel_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      send_pixel(random_pixel());
    end
    pixel_valid <= 1'b0;
    quiet = 1'b0;

    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/hsl_pkg.sv
hdl/hsl_prep.sv
hdl/hsl_div_cell.sv
hdl/hsl_out_buf.sv
hdl/rgb_to_hsl_converter.sv
hdl/hsl_chk.sv
test/hsl_checker.sv
test/testbench.sv
